/* design/pgpu_pkg.sv */
// package for the palette grid pixel upscaler
// shared constants, register indexes, palette and controller command types
// no dependencies
`default_nettype none

package pgpu_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int PALETTE_ENTRIES = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_COLUMNS   = 3'd0,
        REG_PATTERN_ROWS      = 3'd1,
        REG_CELL_PIXEL_WIDTH  = 3'd2,
        REG_CELL_PIXEL_HEIGHT = 3'd3,
        REG_GRID_THICKNESS    = 3'd4,
        REG_GRID_RGBA         = 3'd5,
        REG_SCHEME_RAW        = 3'd6,
        REG_COLORS_IN_USE     = 3'd7
    } t_cfg_idx;

    localparam logic [8:0]  RST_PATTERN_COLUMNS   = 9'd1;
    localparam logic [10:0] RST_PATTERN_ROWS      = 11'd1;
    localparam logic [4:0]  RST_CELL_PIXEL_WIDTH  = 5'd4;
    localparam logic [4:0]  RST_CELL_PIXEL_HEIGHT = 5'd4;
    localparam logic [3:0]  RST_GRID_THICKNESS    = 4'd1;
    localparam logic [31:0] RST_GRID_RGBA         = 32'haaaa_aaaa;
    localparam logic        RST_SCHEME_RAW        = 1'b0;
    localparam logic [7:0]  RST_COLORS_IN_USE     = 8'd1;

    localparam logic [10:0] MAX_ROWS     = 11'd1024;
    localparam logic [4:0]  MAX_CELL_PIX = 5'd16;
    localparam logic [3:0]  MAX_GRID     = 4'd8;
    localparam logic [7:0]  GRAY_FULL    = 8'd255;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    localparam logic [31:0] PALETTE [PALETTE_ENTRIES] = '{
        32'h27ae60ff, 32'h3498dbff, 32'he67e22ff, 32'hc0392bff
    };

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    typedef struct packed {
        logic load_cell;
        logic emit;
        logic out_load;
    } t_cmd;

endpackage

`default_nettype wire

/* design/pgpu_in_if.sv */
// input channel of the palette grid pixel upscaler
// valid/ready handshake with load or emit word; no dependencies
`default_nettype none

interface pgpu_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] opcode;
    logic [7:0] column;
    logic [7:0] cell_color;

    modport source (output valid, output opcode, output column, output cell_color,
                    input ready);
    modport sink   (input valid, input opcode, input column, input cell_color,
                    output ready);
endinterface

`default_nettype wire

/* design/pgpu_out_if.sv */
// output channel of the palette grid pixel upscaler
// valid/ready handshake with one rgba pixel word; no dependencies
`default_nettype none

interface pgpu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

/* design/pgpu_ctrl.sv */
// controller of the palette grid pixel upscaler
// handshake state machine, issues commands to pgpu_datapath; uses pgpu_pkg
`default_nettype none

module pgpu_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_opcode,
    output logic              o_in_ready,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output pgpu_pkg::t_cmd    o_cmd
);

    pgpu_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_load;

    assign o_in_ready = (r_state == pgpu_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == pgpu_pkg::S_LOOK) && (!r_out_valid || i_out_ready);

    assign o_cmd.load_cell = w_accept && (i_in_opcode == pgpu_pkg::OP_LOAD);
    assign o_cmd.emit      = w_accept && (i_in_opcode == pgpu_pkg::OP_EMIT);
    assign o_cmd.out_load  = w_out_load;
    assign o_out_valid     = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pgpu_pkg::S_IDLE: begin
                if (o_cmd.emit) begin
                    n_state = pgpu_pkg::S_LOOK;
                end
            end
            pgpu_pkg::S_LOOK: begin
                if (w_out_load) begin
                    n_state = pgpu_pkg::S_IDLE;
                end
            end
            default: n_state = pgpu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        priority if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgpu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* design/pgpu_datapath.sv */
// datapath of the palette grid pixel upscaler
// config registers, row store memory, raster counters, color lookup, output word
// uses pgpu_pkg; driven by pgpu_ctrl commands
`default_nettype none

module pgpu_datapath #(
    parameter int MAX_COLUMNS = pgpu_pkg::MAX_COLUMNS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  pgpu_pkg::t_cmd               i_cmd,
    input  wire  [7:0]                         i_column,
    input  wire  [7:0]                         i_cell_color,
    input  wire                                i_cfg_we,
    input  wire  [pgpu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [pgpu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [7:0]                         o_alpha,
    output logic                               o_row_end,
    output logic                               o_frame_end
);

    localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNTW  = $clog2(MAX_COLUMNS + 1);
    localparam int CLW   = (CNTW > 9) ? CNTW + 1 : 10;
    localparam logic [AW-1:0]  COL_LAST = AW'(MAX_COLUMNS - 1);
    localparam logic [CLW-1:0] COL_MAX  = CLW'(MAX_COLUMNS);

    // config registers
    logic [8:0]  r_pattern_columns;
    logic [10:0] r_pattern_rows;
    logic [4:0]  r_cell_pixel_width;
    logic [4:0]  r_cell_pixel_height;
    logic [3:0]  r_grid_thickness;
    logic [31:0] r_grid_rgba;
    logic        r_scheme_raw;
    logic [7:0]  r_colors_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_columns   <= pgpu_pkg::RST_PATTERN_COLUMNS;
            r_pattern_rows      <= pgpu_pkg::RST_PATTERN_ROWS;
            r_cell_pixel_width  <= pgpu_pkg::RST_CELL_PIXEL_WIDTH;
            r_cell_pixel_height <= pgpu_pkg::RST_CELL_PIXEL_HEIGHT;
            r_grid_thickness    <= pgpu_pkg::RST_GRID_THICKNESS;
            r_grid_rgba         <= pgpu_pkg::RST_GRID_RGBA;
            r_scheme_raw        <= pgpu_pkg::RST_SCHEME_RAW;
            r_colors_in_use     <= pgpu_pkg::RST_COLORS_IN_USE;
        end else if (i_cfg_we) begin
            unique case (pgpu_pkg::t_cfg_idx'(i_cfg_idx))
                pgpu_pkg::REG_PATTERN_COLUMNS:   r_pattern_columns   <= i_cfg_data[8:0];
                pgpu_pkg::REG_PATTERN_ROWS:      r_pattern_rows      <= i_cfg_data[10:0];
                pgpu_pkg::REG_CELL_PIXEL_WIDTH:  r_cell_pixel_width  <= i_cfg_data[4:0];
                pgpu_pkg::REG_CELL_PIXEL_HEIGHT: r_cell_pixel_height <= i_cfg_data[4:0];
                pgpu_pkg::REG_GRID_THICKNESS:    r_grid_thickness    <= i_cfg_data[3:0];
                pgpu_pkg::REG_GRID_RGBA:         r_grid_rgba         <= i_cfg_data[31:0];
                pgpu_pkg::REG_SCHEME_RAW:        r_scheme_raw        <= i_cfg_data[0];
                pgpu_pkg::REG_COLORS_IN_USE:     r_colors_in_use     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [CLW-1:0] w_cols;
    logic [10:0]    w_rows;
    logic [4:0]     w_pw;
    logic [4:0]     w_ph;
    logic [3:0]     w_gw;
    logic [7:0]     w_cu;

    always_comb begin
        if (r_pattern_columns == 9'd0) begin
            w_cols = CLW'(1);
        end else if (CLW'(r_pattern_columns) > COL_MAX) begin
            w_cols = COL_MAX;
        end else begin
            w_cols = CLW'(r_pattern_columns);
        end
        if (r_pattern_rows == 11'd0) begin
            w_rows = 11'd1;
        end else if (r_pattern_rows > pgpu_pkg::MAX_ROWS) begin
            w_rows = pgpu_pkg::MAX_ROWS;
        end else begin
            w_rows = r_pattern_rows;
        end
        if (r_cell_pixel_width == 5'd0) begin
            w_pw = 5'd1;
        end else if (r_cell_pixel_width > pgpu_pkg::MAX_CELL_PIX) begin
            w_pw = pgpu_pkg::MAX_CELL_PIX;
        end else begin
            w_pw = r_cell_pixel_width;
        end
        if (r_cell_pixel_height == 5'd0) begin
            w_ph = 5'd1;
        end else if (r_cell_pixel_height > pgpu_pkg::MAX_CELL_PIX) begin
            w_ph = pgpu_pkg::MAX_CELL_PIX;
        end else begin
            w_ph = r_cell_pixel_height;
        end
        w_gw = (r_grid_thickness > pgpu_pkg::MAX_GRID) ? pgpu_pkg::MAX_GRID : r_grid_thickness;
        w_cu = (r_colors_in_use == 8'd0) ? 8'd1 : r_colors_in_use;
    end

    // elaboration-time tables: load position wrap and gray ramp step
    logic [AW-1:0] w_mod_tab  [256];
    logic [7:0]    w_step_tab [256];

    for (genvar g = 0; g < 256; g++) begin : g_tab
        localparam logic [AW-1:0] MOD_VAL  = AW'(g % MAX_COLUMNS);
        localparam logic [7:0]    STEP_VAL =
            8'(int'(pgpu_pkg::GRAY_FULL) / ((g == 0) ? 1 : g));
        assign w_mod_tab[g]  = MOD_VAL;
        assign w_step_tab[g] = STEP_VAL;
    end

    // row store
    logic [7:0] r_mem [MAX_COLUMNS];
    logic [7:0] r_rd_data;
    logic [AW-1:0] r_cell_col, n_cell_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cell) begin
            r_mem[w_mod_tab[i_column]] <= i_cell_color;
        end
        if (i_cmd.emit) begin
            r_rd_data <= r_mem[r_cell_col];
        end
    end

    // raster counters
    logic [4:0] r_phase_x, n_phase_x;
    logic       r_in_grid_col, n_in_grid_col;
    logic [9:0] r_cell_row, n_cell_row;
    logic [4:0] r_phase_y, n_phase_y;
    logic       r_in_grid_row, n_in_grid_row;

    logic          w_px_end, w_gx_end, w_py_end, w_gy_end;
    logic          w_col_end, w_row_end;
    logic          w_last_x, w_last_y;
    logic [AW-1:0] w_col_inc;

    assign w_px_end  = ({1'b0, r_phase_x} + 6'd1) >= {1'b0, w_pw};
    assign w_gx_end  = ({1'b0, r_phase_x} + 6'd1) >= {2'b0, w_gw};
    assign w_py_end  = ({1'b0, r_phase_y} + 6'd1) >= {1'b0, w_ph};
    assign w_gy_end  = ({1'b0, r_phase_y} + 6'd1) >= {2'b0, w_gw};
    assign w_col_end = (CLW'(r_cell_col) + CLW'(1)) >= w_cols;
    assign w_row_end = ({1'b0, r_cell_row} + 11'd1) >= w_rows;
    assign w_last_x  = !r_in_grid_col && w_col_end && w_px_end;
    assign w_last_y  = w_last_x && !r_in_grid_row && w_row_end && w_py_end;
    assign w_col_inc = (r_cell_col == COL_LAST) ? '0 : r_cell_col + AW'(1);

    always_comb begin
        n_cell_col    = r_cell_col;
        n_phase_x     = r_phase_x;
        n_in_grid_col = r_in_grid_col;
        n_cell_row    = r_cell_row;
        n_phase_y     = r_phase_y;
        n_in_grid_row = r_in_grid_row;
        if (r_in_grid_col) begin
            if (w_gx_end) begin
                n_in_grid_col = 1'b0;
                n_phase_x     = 5'd0;
                n_cell_col    = w_col_inc;
            end else begin
                n_phase_x = r_phase_x + 5'd1;
            end
        end else if (w_px_end) begin
            n_phase_x = 5'd0;
            priority if (w_last_x) begin
                n_cell_col = '0;
            end else if (w_gw != 4'd0) begin
                n_in_grid_col = 1'b1;
            end else begin
                n_cell_col = w_col_inc;
            end
        end else begin
            n_phase_x = r_phase_x + 5'd1;
        end
        if (w_last_x) begin
            if (r_in_grid_row) begin
                if (w_gy_end) begin
                    n_in_grid_row = 1'b0;
                    n_phase_y     = 5'd0;
                    n_cell_row    = r_cell_row + 10'd1;
                end else begin
                    n_phase_y = r_phase_y + 5'd1;
                end
            end else if (w_py_end) begin
                n_phase_y = 5'd0;
                priority if (w_row_end) begin
                    n_cell_row = 10'd0;
                end else if (w_gw != 4'd0) begin
                    n_in_grid_row = 1'b1;
                end else begin
                    n_cell_row = r_cell_row + 10'd1;
                end
            end else begin
                n_phase_y = r_phase_y + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_col    <= '0;
            r_phase_x     <= 5'd0;
            r_in_grid_col <= 1'b0;
            r_cell_row    <= 10'd0;
            r_phase_y     <= 5'd0;
            r_in_grid_row <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cell_col    <= n_cell_col;
            r_phase_x     <= n_phase_x;
            r_in_grid_col <= n_in_grid_col;
            r_cell_row    <= n_cell_row;
            r_phase_y     <= n_phase_y;
            r_in_grid_row <= n_in_grid_row;
        end
    end

    // per-pixel flags taken with the emit word
    logic r_is_grid, r_last_x, r_last_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_is_grid <= r_in_grid_col || r_in_grid_row;
            r_last_x  <= w_last_x;
            r_last_y  <= w_last_y;
        end
    end

    // color lookup
    logic [7:0]  w_k;
    logic [15:0] w_prod;
    logic [7:0]  w_gray;
    logic [31:0] w_color;

    assign w_k    = r_rd_data - 8'd1;
    assign w_prod = w_k * w_step_tab[w_cu];
    assign w_gray = w_prod[7:0];

    always_comb begin
        priority if (r_is_grid) begin
            w_color = r_grid_rgba;
        end else if (r_rd_data == 8'd0) begin
            w_color = 32'd0;
        end else if (!r_scheme_raw || (w_k < 8'(pgpu_pkg::PALETTE_ENTRIES))) begin
            w_color = pgpu_pkg::PALETTE[w_k[1:0]];
        end else begin
            w_color = {w_gray, w_gray, w_gray, pgpu_pkg::ALPHA_OPAQUE};
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_red       <= w_color[31:24];
            o_green     <= w_color[23:16];
            o_blue      <= w_color[15:8];
            o_alpha     <= w_color[7:0];
            o_row_end   <= r_last_x;
            o_frame_end <= r_last_y;
        end
    end

endmodule

`default_nettype wire

/* design/palette_grid_pixel_upscaler_unit.sv */
// top level of the palette grid pixel upscaler
// joins pgpu_ctrl and pgpu_datapath; uses pgpu_pkg, pgpu_in_if, pgpu_out_if
//
// usage:
// i_in carries load words (opcode 0: column, cell_color into the row store)
// and emit words (opcode 1: produce the next pixel in raster order).
// o_out carries one rgba pixel word per emit, with row_end and frame_end.
// the config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one register per
// cycle; write only while no emit is outstanding.
// a load word writes the row store. an emit word does the row store read,
// then the palette or gray ramp lookup into the output register.
// the next word is taken while the previous pixel waits in the output
// register; if that register is still full when a new pixel is ready, the
// unit holds the new pixel and input ready stays low until o_out takes one.
// synchronous reset returns raster position to the first pixel and config
// registers to their defaults; the row store is not cleared.
`default_nettype none

module palette_grid_pixel_upscaler_unit #(
    parameter int MAX_COLUMNS = pgpu_pkg::MAX_COLUMNS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    pgpu_in_if.sink                         i_in,
    pgpu_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire  [pgpu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [pgpu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pgpu_pkg::t_cmd w_cmd;
    logic           w_in_ready;
    logic           w_out_valid;

    pgpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode[0]),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    pgpu_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_column     (i_in.column),
        .i_cell_color (i_in.cell_color),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_red        (o_out.red),
        .o_green      (o_out.green),
        .o_blue       (o_out.blue),
        .o_alpha      (o_out.alpha),
        .o_row_end    (o_out.row_end),
        .o_frame_end  (o_out.frame_end)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.frame_end || o_out.row_end))
        else $error("frame_end without row_end");

    a_emit_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.opcode[0]) |=> !i_in.ready)
        else $error("word taken during pixel lookup");

    a_pixel_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("pixel word without lookup");

    a_load_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.opcode[0] && !o_out.valid) |=> !o_out.valid)
        else $error("pixel word from a load");

endmodule

`default_nettype wire
